@@ hw/rtl/sst_pkg.sv @@
// ----------------------------------------------------------------------------
// Sprite sequence timer package
// Shared field widths, command and register codes, reset values, and the
// status struct of the serial divider.
// ----------------------------------------------------------------------------
package sst_pkg;

  // Field widths fixed by the interface
  localparam int CMD_W         = 2;
  localparam int TIME_W        = 32;
  localparam int FRAME_IDX_W   = 12;
  localparam int FRAME_COUNT_W = 13;
  localparam int CFG_IDX_W     = 2;
  localparam int CFG_DATA_W    = 32;

  // Command codes
  localparam logic [CMD_W-1:0] CMD_STAMP   = 2'd0;
  localparam logic [CMD_W-1:0] CMD_DELTA   = 2'd1;
  localparam logic [CMD_W-1:0] CMD_RESTART = 2'd2;
  localparam logic [CMD_W-1:0] CMD_LAST    = 2'd3;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_COUNT  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_PERIOD = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_LOOP_ENABLE  = 2'd2;

  // Register reset values
  localparam logic [FRAME_COUNT_W-1:0] FRAME_COUNT_RST  = 13'd1;
  localparam logic [TIME_W-1:0]        FRAME_PERIOD_RST = 32'd33333;
  localparam logic                     LOOP_ENABLE_RST  = 1'b1;

  // Serial divider status
  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage

@@ hw/rtl/sst_divider.sv @@
// ----------------------------------------------------------------------------
// Serial restoring divider
// One quotient bit per cycle: once the last bit is in, done pulses and the
// quotient and remainder hold until the next start.
// ----------------------------------------------------------------------------
module sst_divider #(
  parameter int DVD_W = 34,
  parameter int DIV_W = 32
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  input  logic [DVD_W-1:0]      dividend,
  input  logic [DIV_W-1:0]      divisor,
  output sst_pkg::div_stat_t    stat,
  output logic [DVD_W-1:0]      quotient,
  output logic [DIV_W-1:0]      remainder
);

  localparam int CNT_W = $clog2(DVD_W + 1);

  logic [DVD_W-1:0] dq;       // dividend bits out at the top, quotient bits in
  logic [DIV_W-1:0] rem;
  logic [DIV_W-1:0] dvs;
  logic [CNT_W-1:0] count;
  logic             busy;
  logic             done;

  logic [DIV_W:0]   trial;
  logic [DIV_W:0]   diff;
  logic             qbit;

  // One compare-subtract step
  always_comb begin
    trial = {rem, dq[DVD_W-1]};
    diff  = trial - {1'b0, dvs};
    qbit  = (trial >= {1'b0, dvs});
  end

  // Control
  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      done  <= 1'b0;
      count <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy  <= 1'b1;
        count <= CNT_W'(DVD_W);
      end else if (busy) begin
        count <= count - 1'b1;
        if (count == CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // Datapath
  always_ff @(posedge clk) begin
    if (start) begin
      dq  <= dividend;
      rem <= '0;
      dvs <= divisor;
    end else if (busy) begin
      dq  <= {dq[DVD_W-2:0], qbit};
      rem <= qbit ? diff[DIV_W-1:0] : trial[DIV_W-1:0];
    end
  end

  assign stat.busy = busy;
  assign stat.done = done;
  assign quotient  = dq;
  assign remainder = rem;

endmodule

@@ hw/rtl/sprite_sequence_frame_timer.sv @@
// ----------------------------------------------------------------------------
// Sprite sequence frame timer
// Turns time stamps and deltas into an animation frame index with wrap or
// clamp at the end of the sequence.
// ----------------------------------------------------------------------------
// Sequence: restart, jump and stopped deltas go straight to ST_WB; a delta that
//   stays within the period passes ST_ADD and ST_CMP, an advancing one (step or
//   clamp) also ST_DIV1 and ST_ADV, and one that wraps ST_DIV2 before ST_WB.
// Throughput: one command at a time; the shared bit-serial divider runs once
//   for the frame step and the accumulator remainder, once more for a wrap.
// Reset: synchronous; frame 0, times 0, advancing 1, count 1, period 33333, loop on.
module sprite_sequence_frame_timer #(
  parameter int MAX_FRAMES = 4096,
  parameter int TIME_BITS  = 32
) (
  input  logic                                clk,
  input  logic                                rst,
  // command channel
  input  logic                                cmd_valid,
  output logic                                cmd_stall,
  input  logic [sst_pkg::CMD_W-1:0]           cmd,
  input  logic [sst_pkg::TIME_W-1:0]          time_value,
  // result channel
  output logic                                res_valid,
  input  logic                                res_stall,
  output logic [sst_pkg::FRAME_IDX_W-1:0]     frame_index,
  output logic                                is_last,
  output logic                                running,
  // configuration write channel
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [sst_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [sst_pkg::CFG_DATA_W-1:0]      cfg_data
);

  localparam int TB     = TIME_BITS;
  localparam int SUM_W  = TB + 1;
  localparam int T_W    = TB + 2;
  localparam int FB     = $clog2(MAX_FRAMES);
  localparam int CNT_W  = $clog2(MAX_FRAMES + 1);
  localparam int DIV_W  = (TB > CNT_W) ? TB : CNT_W;
  localparam int CMP_W  = ((CNT_W > sst_pkg::FRAME_COUNT_W) ? CNT_W
                                                            : sst_pkg::FRAME_COUNT_W) + 1;
  localparam bit SAT_ON = (TB >= 64);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_ADD  = 3'd1;
  localparam logic [2:0] ST_CMP  = 3'd2;
  localparam logic [2:0] ST_DIV1 = 3'd3;
  localparam logic [2:0] ST_ADV  = 3'd4;
  localparam logic [2:0] ST_DIV2 = 3'd5;
  localparam logic [2:0] ST_WB   = 3'd6;

  // Configuration registers
  logic [sst_pkg::FRAME_COUNT_W-1:0] frame_count;
  logic [sst_pkg::TIME_W-1:0]        frame_period;
  logic                              loop_enable;

  // Timer state
  logic [FB-1:0]    idx;
  logic [TB-1:0]    acc;
  logic [TB-1:0]    prev_time;
  logic             advancing;

  // Work registers
  logic [2:0]       state;
  logic [TB-1:0]    delta;
  logic [SUM_W-1:0] sum;
  logic [T_W-1:0]   target;

  // Derived values
  logic [TB-1:0]    tv;
  logic [TB-1:0]    per;
  logic [CNT_W-1:0] cnt;
  logic [CMP_W-1:0] fc_w;
  logic [SUM_W-1:0] sum_full;
  logic [SUM_W-1:0] sum_next;
  logic             cmd_accept;
  logic             res_free;

  // Divider hookup
  logic                  div_start;
  logic [T_W-1:0]        div_dividend;
  logic [DIV_W-1:0]      div_divisor;
  sst_pkg::div_stat_t    div_stat;
  logic [T_W-1:0]        div_quot;
  logic [DIV_W-1:0]      div_rem;

  assign cfg_ready  = 1'b1;
  assign cmd_stall  = (state != ST_IDLE);
  assign cmd_accept = cmd_valid && !cmd_stall;
  assign res_free   = !res_valid || !res_stall;

  // Effective period and frame count
  always_comb begin
    tv   = TB'(time_value);
    per  = TB'(frame_period);
    if (per == '0) begin
      per = TB'(1);
    end
    fc_w = CMP_W'(frame_count);
    if (fc_w == '0) begin
      cnt = CNT_W'(1);
    end else if (fc_w > CMP_W'(MAX_FRAMES)) begin
      cnt = CNT_W'(MAX_FRAMES);
    end else begin
      cnt = fc_w[CNT_W-1:0];
    end
  end

  // Accumulator sum, saturating only at full 64-bit time
  always_comb begin
    sum_full = {1'b0, acc} + {1'b0, delta};
    sum_next = sum_full;
    if (SAT_ON && sum_full[SUM_W-1]) begin
      sum_next = {1'b0, {TB{1'b1}}};
    end
  end

  // Divider operand select: first pass sum / period, second pass target % count
  always_comb begin
    div_start    = 1'b0;
    div_dividend = T_W'(sum);
    div_divisor  = DIV_W'(per);
    if (state == ST_CMP) begin
      div_start = (sum > SUM_W'(per));
    end else if (state == ST_ADV) begin
      div_start    = (target >= T_W'(cnt)) && loop_enable;
      div_dividend = target;
      div_divisor  = DIV_W'(cnt);
    end
  end

  sst_divider #(
    .DVD_W (T_W),
    .DIV_W (DIV_W)
  ) u_div (
    .clk       (clk),
    .rst       (rst),
    .start     (div_start),
    .dividend  (div_dividend),
    .divisor   (div_divisor),
    .stat      (div_stat),
    .quotient  (div_quot),
    .remainder (div_rem)
  );

  // Configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      frame_count  <= sst_pkg::FRAME_COUNT_RST;
      frame_period <= sst_pkg::FRAME_PERIOD_RST;
      loop_enable  <= sst_pkg::LOOP_ENABLE_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        sst_pkg::CFG_FRAME_COUNT:  frame_count  <= cfg_data[sst_pkg::FRAME_COUNT_W-1:0];
        sst_pkg::CFG_FRAME_PERIOD: frame_period <= cfg_data;
        sst_pkg::CFG_LOOP_ENABLE:  loop_enable  <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // Command sequencer and timer state
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      idx       <= '0;
      acc       <= '0;
      prev_time <= '0;
      advancing <= 1'b1;
    end else begin
      case (state)
        ST_IDLE: begin
          if (cmd_accept) begin
            case (cmd)
              sst_pkg::CMD_STAMP: begin
                delta     <= tv - prev_time;
                prev_time <= tv;
                state     <= advancing ? ST_ADD : ST_WB;
              end
              sst_pkg::CMD_DELTA: begin
                delta <= tv;
                state <= advancing ? ST_ADD : ST_WB;
              end
              sst_pkg::CMD_RESTART: begin
                idx       <= '0;
                acc       <= '0;
                advancing <= 1'b1;
                state     <= ST_WB;
              end
              default: begin
                idx   <= FB'(cnt - 1'b1);
                state <= ST_WB;
              end
            endcase
          end
        end
        ST_ADD: begin
          sum   <= sum_next;
          state <= ST_CMP;
        end
        ST_CMP: begin
          // no step unless the sum strictly exceeds one period
          if (div_start) begin
            state <= ST_DIV1;
          end else begin
            acc   <= TB'(sum);
            state <= ST_WB;
          end
        end
        ST_DIV1: begin
          if (div_stat.done) begin
            acc    <= TB'(div_rem);
            target <= T_W'(idx) + div_quot;
            state  <= ST_ADV;
          end
        end
        ST_ADV: begin
          if (target < T_W'(cnt)) begin
            idx   <= FB'(target);
            state <= ST_WB;
          end else if (loop_enable) begin
            state <= ST_DIV2;
          end else begin
            idx       <= FB'(cnt - 1'b1);
            advancing <= 1'b0;
            state     <= ST_WB;
          end
        end
        ST_DIV2: begin
          if (div_stat.done) begin
            idx   <= FB'(div_rem);
            state <= ST_WB;
          end
        end
        ST_WB: begin
          if (res_free) begin
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (state == ST_WB && res_free) begin
      res_valid <= 1'b1;
    end else if (!res_stall) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_WB && res_free) begin
      frame_index <= sst_pkg::FRAME_IDX_W'(idx);
      is_last     <= (CNT_W'(idx) >= cnt - 1'b1);
      running     <= advancing;
    end
  end

  // Checks
  a_div_start_idle: assert property (@(posedge clk) disable iff (rst)
    div_start |-> !div_stat.busy)
    else $error("divider started while busy");

  a_div_done_state: assert property (@(posedge clk) disable iff (rst)
    div_stat.done |-> (state == ST_DIV1 || state == ST_DIV2))
    else $error("divider finished outside a divide state");

  a_accept_leaves_idle: assert property (@(posedge clk) disable iff (rst)
    cmd_accept |=> state != ST_IDLE)
    else $error("accepted command did not start");

  a_stopped_holds: assert property (@(posedge clk) disable iff (rst)
    (cmd_accept && !advancing && (cmd == sst_pkg::CMD_DELTA || cmd == sst_pkg::CMD_STAMP))
    |=> (idx == $past(idx) && acc == $past(acc)))
    else $error("stopped timer moved on a delta");

  a_idx_range: assert property (@(posedge clk) disable iff (rst)
    (CNT_W'(idx) < CNT_W'(MAX_FRAMES)))
    else $error("frame index out of range");

endmodule
